FILE: hw/rtl/frp_pkg.sv
`default_nettype none
package frp_pkg;

  // input beat: one text byte or the end-of-stream mark
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  // output beat: one result
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // result kinds
  localparam logic [2:0] KIND_HEADER  = 3'd0;
  localparam logic [2:0] KIND_LETTER  = 3'd1;
  localparam logic [2:0] KIND_END     = 3'd2;
  localparam logic [2:0] KIND_NONE    = 3'd3;
  localparam logic [2:0] KIND_ILLEGAL = 3'd4;
  localparam logic [2:0] KIND_CTRLA   = 3'd5;

  // character codes
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_CTRLA = 8'h01;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  // number of results one input beat can cause
  localparam int MaxResults = 2;

endpackage
`default_nettype wire

FILE: hw/rtl/fasta_record_parser_top.sv
`default_nettype none
// output: a result appears on out in the cycle after its input beat is accepted
// throughput: one input beat per cycle while out is not stalled; a byte that causes two results
//   (record end and new header mark) holds off input while the two-entry result buffer
//   drains
// reset: synchronous, clears the parser mode to between records and empties
//   the result buffer
module fasta_record_parser_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire frp_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output frp_pkg::out_item_t      out_data
);
  import frp_pkg::*;

  localparam int CountW = $clog2(MaxResults + 1);

  logic              accept;
  logic              pop;
  logic [1:0]        res_count;
  out_item_t         res0;
  out_item_t         res1;
  out_item_t         buf_q [MaxResults];
  logic [CountW-1:0] count;

  // parser with its mode register
  frp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (in_data),
    .res_count (res_count),
    .res0      (res0),
    .res1      (res1)
  );

  // handshakes
  assign out_valid = (count != '0);
  assign out_data  = buf_q[0];
  assign pop       = out_valid && !out_stall;
  assign in_stall  = !((count == '0) || ((count == CountW'(1)) && pop));
  assign accept    = in_valid && !in_stall;

  // result buffer: head is the output register, second slot holds the
  // partner of a two-result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= CountW'(res_count);
    end else if (pop) begin
      count <= count - CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      buf_q[0] <= res0;
      buf_q[1] <= res1;
    end else if (pop) begin
      buf_q[0] <= buf_q[1];
    end
  end

  // buffer never overfills
  assert property (@(posedge clk) disable iff (rst) count <= CountW'(MaxResults))
    else $error("result buffer count out of range");

  // a full buffer holds off input
  assert property (@(posedge clk) disable iff (rst)
    (count == CountW'(MaxResults)) |-> in_stall)
    else $error("input taken while buffer full");

  // a beat that causes results shows one on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (accept && (res_count != 2'd0)) |=> out_valid)
    else $error("result missing after accepted beat");

  // a result that is not last always has its partner queued
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.last) |-> (count == CountW'(MaxResults)))
    else $error("non-final result without partner");

endmodule
`default_nettype wire

FILE: hw/rtl/frp_parser.sv
`default_nettype none
module frp_parser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire frp_pkg::in_item_t item,
  output logic [1:0]             res_count,
  output frp_pkg::out_item_t     res0,
  output frp_pkg::out_item_t     res1
);
  import frp_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_HEADER = 2'd1,
    MODE_SEQ    = 2'd2,
    MODE_ERROR  = 2'd3
  } mode_t;

  mode_t      mode;
  mode_t      mode_next;
  logic [7:0] c;
  logic       eof;
  logic       is_letter;
  logic       is_space;
  logic       is_eol;
  logic [2:0] kind0;
  logic [2:0] kind1;
  logic [7:0] byte0;
  logic [7:0] byte1;

  assign c   = item.in_byte;
  assign eof = item.end_of_input;

  // character classes
  assign is_letter = ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  assign is_eol    = (c == CH_LF) || (c == CH_CR);
  assign is_space  = is_eol || (c == CH_SPACE) || (c == CH_TAB);

  // next mode and results for the current beat
  always_comb begin
    mode_next = mode;
    res_count = 2'd0;
    kind0     = KIND_NONE;
    byte0     = 8'd0;
    kind1     = KIND_HEADER;
    byte1     = 8'd0;
    unique case (mode)
      MODE_IDLE: begin
        if (eof) begin
          res_count = 2'd1;
          kind0     = KIND_NONE;
        end else if (is_space) begin
          res_count = 2'd0;
        end else if (c == CH_GT) begin
          mode_next = MODE_HEADER;
          res_count = 2'd1;
          kind0     = KIND_HEADER;
          byte0     = c;
        end else begin
          mode_next = MODE_ERROR;
          res_count = 2'd1;
          kind0     = KIND_ILLEGAL;
        end
      end
      MODE_HEADER: begin
        if (eof) begin
          mode_next = MODE_IDLE;
          res_count = 2'd1;
          kind0     = KIND_NONE;
        end else if (is_eol) begin
          mode_next = MODE_SEQ;
        end else if (c == CH_CTRLA) begin
          mode_next = MODE_ERROR;
          res_count = 2'd1;
          kind0     = KIND_CTRLA;
        end else begin
          res_count = 2'd1;
          kind0     = KIND_HEADER;
          byte0     = c;
        end
      end
      MODE_SEQ: begin
        if (eof) begin
          mode_next = MODE_IDLE;
          res_count = 2'd1;
          kind0     = KIND_END;
        end else if (c == CH_GT) begin
          // record end, then the new header mark
          mode_next = MODE_HEADER;
          res_count = 2'd2;
          kind0     = KIND_END;
          kind1     = KIND_HEADER;
          byte1     = c;
        end else if (is_letter) begin
          res_count = 2'd1;
          kind0     = KIND_LETTER;
          byte0     = c;
        end
      end
      MODE_ERROR: begin
        res_count = 2'd1;
        kind0     = KIND_ILLEGAL;
      end
      default: begin
        mode_next = MODE_ERROR;
      end
    endcase
  end

  assign res0 = '{kind: kind0, out_byte: byte0, last: (res_count == 2'd1)};
  assign res1 = '{kind: kind1, out_byte: byte1, last: 1'b1};

  // parser mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

endmodule
`default_nettype wire

FILE: verif/fasta_record_checker.sv
module fasta_record_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire frp_pkg::in_item_t  in_data,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire frp_pkg::out_item_t out_data,
  output int                      fail_count,
  output int                      pending,
  output int                      checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import frp_pkg::*;

  // keep the log short when everything goes wrong
  localparam int MaxPrinted = 40;

  typedef enum logic [1:0] {
    BETWEEN_RECORDS,
    IN_HEADER,
    IN_SEQUENCE,
    STUCK_ERROR
  } parse_mode_t;

  parse_mode_t mode;
  out_item_t   predicted_beats[$];

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MaxPrinted) begin
      $display("%0t mismatch: %s", $time, what);
    end
  endtask

  function automatic out_item_t result_of(input logic [2:0] kind, input logic [7:0] b);
    out_item_t r;
    r.kind     = kind;
    r.out_byte = b;
    r.last     = 1'b0;
    return r;
  endfunction

  // next-state decision for one input beat, queues the results it causes
  task automatic parse_byte(input in_item_t beat);
    out_item_t  res [2];
    int         n;
    logic [7:0] c;
    n = 0;
    c = beat.in_byte;
    case (mode)
      BETWEEN_RECORDS: begin
        if (beat.end_of_input) begin
          res[n] = result_of(KIND_NONE, 8'h00);
          n++;
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
          // blanks between records give nothing
        end else if (c == CH_GT) begin
          mode   = IN_HEADER;
          res[n] = result_of(KIND_HEADER, c);
          n++;
        end else begin
          mode   = STUCK_ERROR;
          res[n] = result_of(KIND_ILLEGAL, 8'h00);
          n++;
        end
      end
      IN_HEADER: begin
        if (beat.end_of_input) begin
          // a cut-short header is not a record
          mode   = BETWEEN_RECORDS;
          res[n] = result_of(KIND_NONE, 8'h00);
          n++;
        end else if (c == CH_LF || c == CH_CR) begin
          mode = IN_SEQUENCE;
        end else if (c == CH_CTRLA) begin
          mode   = STUCK_ERROR;
          res[n] = result_of(KIND_CTRLA, 8'h00);
          n++;
        end else begin
          res[n] = result_of(KIND_HEADER, c);
          n++;
        end
      end
      IN_SEQUENCE: begin
        if (beat.end_of_input) begin
          mode   = BETWEEN_RECORDS;
          res[n] = result_of(KIND_END, 8'h00);
          n++;
        end else if (c == CH_GT) begin
          // record end, then the mark of the next header
          mode   = IN_HEADER;
          res[n] = result_of(KIND_END, 8'h00);
          n++;
          res[n] = result_of(KIND_HEADER, c);
          n++;
        end else if ((c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z)) begin
          res[n] = result_of(KIND_LETTER, c);
          n++;
        end
      end
      default: begin
        res[n] = result_of(KIND_ILLEGAL, 8'h00);
        n++;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      res[i].last = (i == n - 1);
      predicted_beats = {predicted_beats, res[i]};
    end
  endtask

  // field by field against the oldest prediction
  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (predicted_beats.size() == 0) begin
      report_mismatch($sformatf("result beat kind %0d byte 0x%02h with nothing predicted",
                                got.kind, got.out_byte));
      return;
    end
    want = predicted_beats.pop_front();
    if (got.kind !== want.kind) begin
      report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                checked, got.kind, want.kind));
    end
    if (got.out_byte !== want.out_byte) begin
      report_mismatch($sformatf("result %0d byte 0x%02h, expected 0x%02h",
                                checked, got.out_byte, want.out_byte));
    end
    if (got.last !== want.last) begin
      report_mismatch($sformatf("result %0d last %0b, expected %0b",
                                checked, got.last, want.last));
    end
    checked++;
  endtask

  // watch both channels
  always @(posedge clk) begin
    if (rst) begin
      mode = BETWEEN_RECORDS;
      predicted_beats.delete();
      fail_count = 0;
      checked    = 0;
      pending    = 0;
    end else begin
      if (out_valid && !out_stall) compare_result(out_data);
      if (in_valid && !in_stall) parse_byte(in_data);
      pending = predicted_beats.size();
    end
  end

endmodule

FILE: verif/fasta_record_parser_top_tb.sv
module fasta_record_parser_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import frp_pkg::*;

  localparam int ItemTarget   = 1800;
  localparam int IdleLimit    = 1000;
  localparam int SettleCycles = 8;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int    fail_count;
  int    pending;
  int    checked;
  int    items_sent   = 0;
  int    records_sent = 0;
  int    idle_cycles  = 0;
  int    stall_left   = 0;
  int    stall_draw;
  bit    steady       = 1'b0;
  string error_path   = "none";

  fasta_record_parser_top i_dut (.*);

  fasta_record_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stall after each accepted beat, none in steady stretches
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      stall_draw = steady ? 0 : $urandom_range(0, 6);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("watchdog: %0d cycles without a beat", IdleLimit);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input beat after a random gap; valid stays high for a back-to-back beat
  task automatic send_beat(input logic [7:0] b, input logic eoi);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= '{in_byte: b, end_of_input: eoi};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // hold input until every predicted result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // one well-formed record with random content, sometimes cut short
  task automatic send_random_record();
    logic [7:0] b;
    steady <= ($urandom_range(0, 7) == 0);
    records_sent++;
    // blanks before the mark are skipped in every mode we can be in here
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0:       b = CH_SPACE;
        1:       b = CH_TAB;
        2:       b = CH_LF;
        default: b = CH_CR;
      endcase
      send_beat(b, 1'b0);
    end
    send_beat(CH_GT, 1'b0);
    // header text: anything but a line end or ctrl-a
    repeat ($urandom_range(0, 12)) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR || b == CH_CTRLA);
      send_beat(b, 1'b0);
    end
    // header cut short by the end of the stream
    if ($urandom_range(0, 15) == 0) begin
      send_beat(8'($urandom_range(0, 255)), 1'b1);
      return;
    end
    send_beat($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
    // sequence lines: mostly letters, some random bytes that are dropped unless they are letters
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(0, 16)) begin
        if ($urandom_range(0, 3) != 0) begin
          b = ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'($urandom_range(0, 25));
        end else begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_GT);
        end
        send_beat(b, 1'b0);
      end
      send_beat(CH_LF, 1'b0);
    end
    // sometimes the stream ends here, now and then twice
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2)) send_beat(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    logic [7:0] b;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // end of stream with no record open
    send_beat(8'hFF, 1'b1);
    // blanks between records
    send_beat(CH_SPACE, 1'b0);
    send_beat(CH_TAB, 1'b0);
    send_beat(CH_LF, 1'b0);
    send_beat(CH_CR, 1'b0);
    // header with extreme bytes and a second mark, ended by cr
    send_beat(CH_GT, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(CH_GT, 1'b0);
    send_beat(CH_CR, 1'b0);
    // letter bounds and their neighbors
    send_beat(CH_LO_A, 1'b0);
    send_beat(CH_LO_Z, 1'b0);
    send_beat(CH_UP_A, 1'b0);
    send_beat(CH_UP_Z, 1'b0);
    send_beat(CH_UP_A - 8'd1, 1'b0);
    send_beat(CH_LO_Z + 8'd1, 1'b0);
    // next mark inside a sequence: record end and header mark
    send_beat(CH_GT, 1'b0);
    // header cut short, then end again between records
    send_beat(8'h78, 1'b0);
    send_beat(8'h00, 1'b1);
    send_beat(8'h5A, 1'b1);
    // end inside a sequence
    send_beat(CH_GT, 1'b0);
    send_beat(CH_LF, 1'b0);
    send_beat(8'h67, 1'b0);
    send_beat(8'h80, 1'b1);
    wait_drained();

    while (items_sent < ItemTarget) begin
      send_random_record();
      if (records_sent % 40 == 0) wait_drained();
    end
    // close whatever is open so the stream is between records
    send_beat(8'($urandom_range(0, 255)), 1'b1);
    wait_drained();

    // the error mode is sticky, so it comes last
    if ($urandom_range(0, 1) == 1) begin
      error_path = "illegal byte between records";
      do b = 8'($urandom_range(0, 255));
      while (b == CH_GT || b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR);
      send_beat(b, 1'b0);
    end else begin
      error_path = "ctrl-a in header";
      send_beat(CH_GT, 1'b0);
      send_beat(CH_CTRLA, 1'b0);
    end
    repeat (8) send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    wait_drained();
    repeat (SettleCycles) @(posedge clk);

    $display("covered %0d input beats: directed cases plus %0d random records",
             items_sent, records_sent);
    $display("%0d results checked, error mode entered by %s", checked, error_path);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
